// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the cipher checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bscrx_pkg.sv
// ----------------------------------------------------------------------------
// bscrx_pkg
// Types and constants shared by the rotate/xor byte stream cipher modules
// ----------------------------------------------------------------------------
`default_nettype none

package bscrx_pkg;

	// key storage and clamp limit
	localparam int KEY_BYTES = 8;

	// configuration port
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_LSB = 3;

	// remainder unit
	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W = 8;
	localparam int REM_BITS_PER_CYCLE = 8;
	localparam int REM_CYCLES = DIVIDEND_W / REM_BITS_PER_CYCLE;
	localparam int REM_CNT_W = (REM_CYCLES > 1) ? $clog2(REM_CYCLES) : 1;

	// register indexes
	typedef enum logic [2:0] {
		REG_CIPHER_MODE  = 3'd0,
		REG_SEED_BYTES   = 3'd1,
		REG_FALLBACK_DIV = 3'd2,
		REG_KEY_A        = 3'd3,
		REG_KEY_A_LENGTH = 3'd4,
		REG_KEY_B        = 3'd5,
		REG_KEY_B_LENGTH = 3'd6
	} reg_idx_t;

	// cipher direction held in cipher_mode
	typedef enum logic {
		MODE_ENCRYPT = 1'b0,
		MODE_DECRYPT = 1'b1
	} cipher_mode_t;

	// register file contents
	typedef struct packed {
		logic        cipher_mode;
		logic [23:0] seed_bytes;
		logic [23:0] fallback_divisors;
		logic [63:0] key_a;
		logic [3:0]  key_a_length;
		logic [63:0] key_b;
		logic [3:0]  key_b_length;
	} cfg_t;

	// remainder unit request and response
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} rem_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIVISOR_W-1:0] rem;
	} rem_rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/bscrx_regs.sv
// ----------------------------------------------------------------------------
// bscrx_regs
// Configuration register file behind an APB-style port
// ----------------------------------------------------------------------------
`default_nettype none

module bscrx_regs (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [bscrx_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [bscrx_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bscrx_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	output bscrx_pkg::cfg_t                     cfg
);
	import bscrx_pkg::*;

	reg_idx_t reg_idx;
	logic     wr_en;
	cfg_t     cfg_q;

	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:REG_IDX_LSB]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cipher_mode       <= 1'b0;
			cfg_q.seed_bytes        <= 24'h000000;
			cfg_q.fallback_divisors <= 24'h010101;
			cfg_q.key_a             <= 64'd0;
			cfg_q.key_a_length      <= 4'd8;
			cfg_q.key_b             <= 64'd0;
			cfg_q.key_b_length      <= 4'd8;
		end else if (wr_en && pready) begin
			case (reg_idx)
				REG_CIPHER_MODE:  cfg_q.cipher_mode       <= pwdata[0];
				REG_SEED_BYTES:   cfg_q.seed_bytes        <= pwdata[23:0];
				REG_FALLBACK_DIV: cfg_q.fallback_divisors <= pwdata[23:0];
				REG_KEY_A:        cfg_q.key_a             <= pwdata[63:0];
				REG_KEY_A_LENGTH: cfg_q.key_a_length      <= pwdata[3:0];
				REG_KEY_B:        cfg_q.key_b             <= pwdata[63:0];
				REG_KEY_B_LENGTH: cfg_q.key_b_length      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_CIPHER_MODE:  prdata = APB_DATA_W'(cfg_q.cipher_mode);
			REG_SEED_BYTES:   prdata = APB_DATA_W'(cfg_q.seed_bytes);
			REG_FALLBACK_DIV: prdata = APB_DATA_W'(cfg_q.fallback_divisors);
			REG_KEY_A:        prdata = APB_DATA_W'(cfg_q.key_a);
			REG_KEY_A_LENGTH: prdata = APB_DATA_W'(cfg_q.key_a_length);
			REG_KEY_B:        prdata = APB_DATA_W'(cfg_q.key_b);
			REG_KEY_B_LENGTH: prdata = APB_DATA_W'(cfg_q.key_b_length);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/bscrx_rem.sv
// ----------------------------------------------------------------------------
// bscrx_rem
// Shared remainder unit, restoring division several dividend bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bscrx_rem (
	input  wire                    clk,
	input  wire                    arst_n,
	input  bscrx_pkg::rem_req_t    req,
	output bscrx_pkg::rem_rsp_t    rsp
);
	import bscrx_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [REM_CNT_W-1:0]  cnt_q;
	logic [DIVIDEND_W-1:0] dvd_q;
	logic [DIVISOR_W-1:0]  div_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  rem_next;

	// compare-subtract steps for one cycle, dividend msb first
	always_comb begin
		logic [DIVISOR_W:0]   t;
		logic [DIVISOR_W-1:0] r;
		r = rem_q;
		t = '0;
		for (int k = 0; k < REM_BITS_PER_CYCLE; k++) begin
			t = {r, dvd_q[DIVIDEND_W-1-k]};
			if (t >= {1'b0, div_q})
				t = t - {1'b0, div_q};
			r = t[DIVISOR_W-1:0];
		end
		rem_next = r;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == REM_CNT_W'(REM_CYCLES - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operands and partial remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << REM_BITS_PER_CYCLE;
			rem_q <= rem_next;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/byte_stream_cipher_rotate_xor.sv
// Flow: a word accepted on s_axis runs the shared multiply-add twice, then the
// key remainders on the 8-bit-per-cycle remainder unit, and the three fallback
// remainders when the key byte is zero, before it shows on m_axis; no new word
// is taken until the last one has been loaded into the output register.
// Reset: arst_n clears all control state; the first word then loads the seeds.
// ----------------------------------------------------------------------------
// byte_stream_cipher_rotate_xor
// Byte stream cipher with running polynomial value, key xor and bit rotation
// ----------------------------------------------------------------------------
`default_nettype none

module byte_stream_cipher_rotate_xor (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration port
	input  wire                                 psel,
	input  wire                                 penable,
	input  wire                                 pwrite,
	input  wire  [bscrx_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire  [bscrx_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [bscrx_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                pready,
	// input words
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [7:0]                          s_axis_tdata,  // [7:0] in_byte
	input  wire                                 s_axis_tlast,  // last_in
	// output words
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // [7:0] out_byte
	output logic                                m_axis_tlast,  // last_out
	output logic                                m_axis_tuser   // [0] divisor_fault
);
	import bscrx_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_RA_GO,
		ST_RA_WAIT,
		ST_RB_GO,
		ST_RB_WAIT,
		ST_KEY,
		ST_FB_GO,
		ST_FB_WAIT,
		ST_OUT
	} state_t;

	cfg_t     cfg;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	state_t      state_q;
	logic        msg_start_q;
	logic [31:0] idx_q;
	logic [31:0] rv_q;
	logic [31:0] acc_q;
	logic [7:0]  mult_a_q;
	logic [7:0]  mult_b_q;
	logic [7:0]  prev_key_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic [7:0]  x1_q;
	logic [7:0]  x2_q;
	logic [7:0]  kt_q;
	logic        fault_q;
	logic [1:0]  fb_cnt_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;
	logic        out_fault_q;

	logic [31:0] mac_a;
	logic [31:0] mac_b;
	logic [31:0] mac_c;
	logic [31:0] mac_prod;
	logic [31:0] mac_out;
	logic [31:0] shifted;
	logic [7:0]  x0;
	logic [7:0]  x3;
	logic [7:0]  kt;
	logic [7:0]  fb_div;
	logic        fb_zero;
	logic [7:0]  fb_val;
	logic [7:0]  res;
	logic        in_acc;
	logic        out_load;

	// key length clamp to one through the key size
	function automatic logic [3:0] clamp_len(input logic [3:0] n);
		if (n == 4'd0)
			return 4'd1;
		else if (n > 4'(KEY_BYTES))
			return 4'(KEY_BYTES);
		else
			return n;
	endfunction

	function automatic logic [7:0] permute_fwd(input logic [7:0] d, input logic [1:0] sel);
		case (sel)
			2'd0:    return {d[3:0], d[7:4]};
			2'd1:    return {d[5:0], d[7:6]};
			2'd2:    return {d[5:4], d[7:6], d[1:0], d[3:2]};
			default: return {d[4:0], d[7:5]};
		endcase
	endfunction

	function automatic logic [7:0] permute_inv(input logic [7:0] d, input logic [1:0] sel);
		case (sel)
			2'd0:    return {d[3:0], d[7:4]};
			2'd1:    return {d[1:0], d[7:2]};
			2'd2:    return {d[5:4], d[7:6], d[1:0], d[3:2]};
			default: return {d[2:0], d[7:3]};
		endcase
	endfunction

	bscrx_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bscrx_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	// shared multiply-add: first mult_b*i + mult_a, then acc*i + shifted value
	assign shifted = $unsigned($signed(rv_q) >>> mult_a_q[2:0]);

	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mac_a = {24'd0, mult_b_q};
				mac_c = {24'd0, mult_a_q};
			end
			default: begin
				mac_a = acc_q;
				mac_c = shifted;
			end
		endcase
	end

	assign mac_b    = idx_q;
	assign mac_prod = mac_a * mac_b;
	assign mac_out  = mac_prod + mac_c;

	// fallback divisor for the current remainder
	assign fb_div  = cfg.fallback_divisors[{fb_cnt_q, 3'b000} +: 8];
	assign fb_zero = (fb_div == 8'd0);
	assign fb_val  = fb_zero ? 8'd0 : rem_rsp.rem;

	// remainder requests
	always_comb begin
		rem_req.start    = 1'b0;
		rem_req.dividend = idx_q;
		rem_req.divisor  = fb_div;
		case (state_q)
			ST_RA_GO: begin
				rem_req.start   = 1'b1;
				rem_req.divisor = {4'd0, clamp_len(cfg.key_a_length)};
			end
			ST_RB_GO: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = idx_q + {24'd0, x1_q};
				rem_req.divisor  = {4'd0, clamp_len(cfg.key_b_length)};
			end
			ST_FB_GO: rem_req.start = 1'b1;
			default: ;
		endcase
	end

	// key byte from the running value, key bytes and feedback
	assign x0 = rv_q[31:24] ^ rv_q[23:16] ^ rv_q[15:8] ^ rv_q[7:0];
	assign x3 = rv_q[10:3] + {prev_key_q[6:0], 1'b0};
	assign kt = x0 ^ x1_q ^ x2_q ^ x3;

	// output byte
	assign res = cfg.cipher_mode ? permute_inv(data_q ^ kt_q, rv_q[1:0])
	                             : (permute_fwd(data_q, rv_q[1:0]) ^ kt_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			msg_start_q <= 1'b1;
			idx_q       <= '0;
			rv_q        <= '0;
			acc_q       <= '0;
			mult_a_q    <= '0;
			mult_b_q    <= '0;
			prev_key_q  <= '0;
			data_q      <= '0;
			last_q      <= 1'b0;
			x1_q        <= '0;
			x2_q        <= '0;
			kt_q        <= '0;
			fault_q     <= 1'b0;
			fb_cnt_q    <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_fault_q <= 1'b0;
		end else begin
			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= res;
				out_last_q  <= last_q;
				out_fault_q <= fault_q;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						data_q <= s_axis_tdata;
						last_q <= s_axis_tlast;
						if (msg_start_q) begin
							idx_q       <= '0;
							mult_a_q    <= cfg.seed_bytes[7:0];
							prev_key_q  <= cfg.seed_bytes[15:8];
							rv_q        <= {24'd0, cfg.seed_bytes[23:16]};
							mult_b_q    <= '0;
							msg_start_q <= 1'b0;
						end
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					acc_q   <= mac_out;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					rv_q    <= mac_out;
					state_q <= ST_RA_GO;
				end
				ST_RA_GO: state_q <= ST_RA_WAIT;
				ST_RA_WAIT: begin
					if (rem_rsp.done) begin
						x1_q    <= cfg.key_a[{rem_rsp.rem[2:0], 3'b000} +: 8];
						state_q <= ST_RB_GO;
					end
				end
				ST_RB_GO: state_q <= ST_RB_WAIT;
				ST_RB_WAIT: begin
					if (rem_rsp.done) begin
						x2_q    <= cfg.key_b[{rem_rsp.rem[2:0], 3'b000} +: 8];
						state_q <= ST_KEY;
					end
				end
				ST_KEY: begin
					kt_q     <= kt;
					fault_q  <= 1'b0;
					fb_cnt_q <= '0;
					state_q  <= (kt == 8'd0) ? ST_FB_GO : ST_OUT;
				end
				ST_FB_GO: state_q <= ST_FB_WAIT;
				ST_FB_WAIT: begin
					if (rem_rsp.done) begin
						fault_q <= fault_q | fb_zero;
						case (fb_cnt_q)
							2'd0:    kt_q <= fb_val;
							2'd1:    x1_q <= fb_val;
							default: x2_q <= fb_val;
						endcase
						if (fb_cnt_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							fb_cnt_q <= fb_cnt_q + 2'd1;
							state_q  <= ST_FB_GO;
						end
					end
				end
				ST_OUT: begin
					if (out_load) begin
						mult_a_q    <= x1_q;
						mult_b_q    <= x2_q;
						prev_key_q  <= kt_q;
						idx_q       <= idx_q + 32'd1;
						msg_start_q <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_fault_q;

endmodule

`default_nettype wire

// File: rtl/core/bscrx_checker.sv
// ----------------------------------------------------------------------------
// bscrx_checker
// Port-level checks for the byte stream cipher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bscrx_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_axis_tvalid,
	input wire       s_axis_tready,
	input wire       m_axis_tvalid,
	input wire       m_axis_tready,
	input wire [7:0] m_axis_tdata,
	input wire       m_axis_tlast,
	input wire       m_axis_tuser
);

	// stalled output word stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "output word changed while stalled")

	// one word at a time: busy right after an accept
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a word is in work")

	// a fresh result never appears the cycle after an accept
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared before the word was processed")

	// ready only while idle, so no accept in the cycle a word is loaded out
	`ASSERT_SAME(a_no_accept_on_rise, clk, arst_n, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready), "result rose right after an accept")

endmodule

bind byte_stream_cipher_rotate_xor bscrx_checker u_bscrx_checker (.*);

`default_nettype wire

// File: tb/byte_stream_cipher_rotate_xor_checker.sv
// ----------------------------------------------------------------------------
// byte_stream_cipher_rotate_xor_checker
// Watches the config port and both streams, predicts every output word of
// the rotate/xor byte cipher and compares it with what the block produces
// ----------------------------------------------------------------------------

module byte_stream_cipher_rotate_xor_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [bscrx_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire [bscrx_pkg::APB_DATA_W-1:0]  pwdata,
	input  wire                              pready,
	input  wire                              s_axis_tvalid,
	input  wire                              s_axis_tready,
	input  wire [7:0]                        s_axis_tdata,  // [7:0] in_byte
	input  wire                              s_axis_tlast,  // last_in
	input  wire                              m_axis_tvalid,
	input  wire                              m_axis_tready,
	input  wire [7:0]                        m_axis_tdata,  // [7:0] out_byte
	input  wire                              m_axis_tlast,  // last_out
	input  wire                              m_axis_tuser,  // [0] divisor_fault
	output int                               fail_count,
	output int                               pending_words
);

	localparam int REPORT_LIMIT = 10;

	// bit permutation picked by the two low bits of the running value
	typedef enum logic [1:0] {
		PERM_NIBBLE_SWAP = 2'd0,
		PERM_ROT2        = 2'd1,
		PERM_PAIR_SWAP   = 2'd2,
		PERM_ROT3        = 2'd3
	} perm_sel_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       fault;
	} cipher_word_t;

	bscrx_pkg::cfg_t cfg;

	// cipher state mirror
	logic [31:0] byte_idx;
	logic [31:0] run_val;
	logic [7:0]  mul_a;
	logic [7:0]  mul_b;
	logic [7:0]  last_key;
	logic        msg_start;

	cipher_word_t expected_q[$];
	cipher_word_t want;
	cipher_word_t got;
	int errors;

	function automatic logic [3:0] eff_len(input logic [3:0] n);
		if (n == 4'd0)
			return 4'd1;
		if (n > bscrx_pkg::KEY_BYTES)
			return 4'(bscrx_pkg::KEY_BYTES);
		return n;
	endfunction

	function automatic logic [7:0] key_at(input logic [63:0] key, input logic [31:0] pos);
		return key[pos[2:0]*8 +: 8];
	endfunction

	// zero divisor gives zero, the fault is flagged by the caller
	function automatic logic [7:0] safe_mod(input logic [31:0] v, input logic [7:0] d);
		if (d == 8'd0)
			return 8'd0;
		return 8'(v % {24'd0, d});
	endfunction

	function automatic logic [7:0] permute_fwd(input logic [7:0] d, input logic [1:0] sel);
		case (perm_sel_t'(sel))
			PERM_NIBBLE_SWAP: return {d[3:0], d[7:4]};
			PERM_ROT2:        return {d[5:0], d[7:6]};
			PERM_PAIR_SWAP:   return {d[5:4], d[7:6], d[1:0], d[3:2]};
			default:          return {d[4:0], d[7:5]};
		endcase
	endfunction

	function automatic logic [7:0] permute_inv(input logic [7:0] d, input logic [1:0] sel);
		case (perm_sel_t'(sel))
			PERM_NIBBLE_SWAP: return {d[3:0], d[7:4]};
			PERM_ROT2:        return {d[1:0], d[7:2]};
			PERM_PAIR_SWAP:   return {d[5:4], d[7:6], d[1:0], d[3:2]};
			default:          return {d[2:0], d[7:3]};
		endcase
	endfunction

	// advance the cipher state by one byte and return the word it produces
	function cipher_word_t cipher_next(input logic [7:0] din, input logic lin);
		logic [31:0]  i;
		logic [31:0]  shifted;
		logic [31:0]  y;
		logic [31:0]  pos_b;
		logic [7:0]   x0;
		logic [7:0]   x1;
		logic [7:0]   x2;
		logic [7:0]   x3;
		logic [7:0]   kt;
		logic         fault;
		cipher_word_t w;

		// first byte of a message reloads from the seeds
		if (msg_start) begin
			byte_idx  = 32'd0;
			mul_a     = cfg.seed_bytes[7:0];
			last_key  = cfg.seed_bytes[15:8];
			run_val   = {24'd0, cfg.seed_bytes[23:16]};
			mul_b     = 8'd0;
			msg_start = 1'b0;
		end
		i = byte_idx;

		// polynomial update with arithmetic-shifted feedback
		shifted = $signed(run_val) >>> mul_a[2:0];
		y = {24'd0, mul_b} * i * i + {24'd0, mul_a} * i + shifted;
		run_val = y;

		// key byte from value folding, both keys and the previous key byte
		x0 = y[31:24] ^ y[23:16] ^ y[15:8] ^ y[7:0];
		x1 = key_at(cfg.key_a, i % {28'd0, eff_len(cfg.key_a_length)});
		pos_b = i + {24'd0, x1};
		x2 = key_at(cfg.key_b, pos_b % {28'd0, eff_len(cfg.key_b_length)});
		x3 = y[10:3] + {last_key[6:0], 1'b0};
		kt = x0 ^ x1 ^ x2 ^ x3;
		fault = 1'b0;

		// zero key byte falls back to index remainders
		if (kt == 8'd0) begin
			fault = (cfg.fallback_divisors[7:0] == 8'd0) ||
				(cfg.fallback_divisors[15:8] == 8'd0) ||
				(cfg.fallback_divisors[23:16] == 8'd0);
			kt = safe_mod(i, cfg.fallback_divisors[7:0]);
			x1 = safe_mod(i, cfg.fallback_divisors[15:8]);
			x2 = safe_mod(i, cfg.fallback_divisors[23:16]);
		end
		mul_a    = x1;
		mul_b    = x2;
		last_key = kt;

		if (bscrx_pkg::cipher_mode_t'(cfg.cipher_mode) == bscrx_pkg::MODE_ENCRYPT)
			w.data = permute_fwd(din, y[1:0]) ^ kt;
		else
			w.data = permute_inv(din ^ kt, y[1:0]);
		w.last  = lin;
		w.fault = fault;

		byte_idx = i + 32'd1;
		if (lin)
			msg_start = 1'b1;
		return w;
	endfunction

	// config mirror, prediction on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.cipher_mode       = bscrx_pkg::MODE_ENCRYPT;
			cfg.seed_bytes        = 24'd0;
			cfg.fallback_divisors = 24'h010101;
			cfg.key_a             = 64'd0;
			cfg.key_a_length      = 4'd8;
			cfg.key_b             = 64'd0;
			cfg.key_b_length      = 4'd8;
			byte_idx  = 32'd0;
			run_val   = 32'd0;
			mul_a     = 8'd0;
			mul_b     = 8'd0;
			last_key  = 8'd0;
			msg_start = 1'b1;
			errors    = 0;
			expected_q.delete();
			fail_count    <= 0;
			pending_words <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (bscrx_pkg::reg_idx_t'(paddr[bscrx_pkg::REG_IDX_LSB +: 3]))
					bscrx_pkg::REG_CIPHER_MODE:  cfg.cipher_mode       = pwdata[0];
					bscrx_pkg::REG_SEED_BYTES:   cfg.seed_bytes        = pwdata[23:0];
					bscrx_pkg::REG_FALLBACK_DIV: cfg.fallback_divisors = pwdata[23:0];
					bscrx_pkg::REG_KEY_A:        cfg.key_a             = pwdata[63:0];
					bscrx_pkg::REG_KEY_A_LENGTH: cfg.key_a_length      = pwdata[3:0];
					bscrx_pkg::REG_KEY_B:        cfg.key_b             = pwdata[63:0];
					bscrx_pkg::REG_KEY_B_LENGTH: cfg.key_b_length      = pwdata[3:0];
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready)
				expected_q.push_back(cipher_next(s_axis_tdata, s_axis_tlast));

			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata, m_axis_tlast, m_axis_tuser};
				if (expected_q.size() == 0) begin
					if (errors < REPORT_LIMIT)
						$display("%0t unexpected word: data %02h last %0b fault %0b",
							$time, got.data, got.last, got.fault);
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got.data !== want.data || got.last !== want.last ||
							got.fault !== want.fault) begin
						if (errors < REPORT_LIMIT)
							$display("%0t mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
								$time, want.data, want.last, want.fault,
								got.data, got.last, got.fault);
						errors++;
					end
				end
			end

			fail_count    <= errors;
			pending_words <= expected_q.size();
		end
	end

endmodule

// File: tb/byte_stream_cipher_rotate_xor_tb.sv
// ----------------------------------------------------------------------------
// byte_stream_cipher_rotate_xor_tb
// Drives the cipher with a directed opening and random phases of byte
// messages under changing key and seed settings, with random stalls on both
// streams, a long output hold-off and drain pauses; the checker beside the
// block predicts and compares every word
// ----------------------------------------------------------------------------

module byte_stream_cipher_rotate_xor_tb;

	localparam int PHASES        = 12;
	localparam int PHASE_WORDS   = 46;
	localparam int MAX_GAP       = 11;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 40;
	localparam int RESET_CYCLES  = 7;

	// cipher_mode values
	localparam logic [63:0] ENCRYPT = 64'(bscrx_pkg::MODE_ENCRYPT);
	localparam logic [63:0] DECRYPT = 64'(bscrx_pkg::MODE_DECRYPT);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                             psel    = 1'b0;
	logic                             penable = 1'b0;
	logic                             pwrite  = 1'b0;
	logic [bscrx_pkg::APB_ADDR_W-1:0] paddr   = '0;
	logic [bscrx_pkg::APB_DATA_W-1:0] pwdata  = '0;
	wire  [bscrx_pkg::APB_DATA_W-1:0] prdata;
	wire                              pready;

	logic       s_tvalid = 1'b0;
	wire        s_tready;
	logic [7:0] s_tdata  = 8'd0;
	logic       s_tlast  = 1'b0;

	wire        m_tvalid;
	logic       m_tready = 1'b0;
	wire  [7:0] m_tdata;
	wire        m_tlast;
	wire        m_tuser;

	int fail_count;
	int pending_words;
	bit calm    = 1'b0;
	bit hold_rx = 1'b0;

	always #2 clk = ~clk;

	byte_stream_cipher_rotate_xor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser)
	);

	byte_stream_cipher_rotate_xor_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tlast  (m_tlast),
		.m_axis_tuser  (m_tuser),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	// run limit
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	// output side: random stalls, one long hold-off on request
	initial begin : rx_side
		int stall;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end else begin
				stall = calm ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	task automatic write_reg(input bscrx_pkg::reg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= bscrx_pkg::APB_ADDR_W'(idx) << bscrx_pkg::REG_IDX_LSB;
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// offer one word after a random gap and wait for it to be taken
	task automatic send_word(input logic [7:0] d, input logic l);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop offering until every expected word is out, then let the block settle
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_words != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_random_msgs(input int count);
		for (int n = 0; n < count; n++)
			send_word(8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	task automatic random_setup;
		logic [63:0] ka;
		logic [63:0] kb;
		logic [23:0] seed;
		logic [23:0] divs;
		int          zero_at;
		case ($urandom_range(0, 3))
			0:       seed = 24'h000000;
			1:       seed = 24'hFFFFFF;
			default: seed = 24'($urandom);
		endcase
		// zero keys make fallback streaks at message start
		case ($urandom_range(0, 4))
			0: begin
				ka = 64'd0;
				kb = 64'd0;
			end
			1: begin
				ka = '1;
				kb = '1;
			end
			default: begin
				ka = {$urandom, $urandom};
				kb = {$urandom, $urandom};
			end
		endcase
		divs = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
			8'($urandom_range(1, 255))};
		case ($urandom_range(0, 3))
			0: divs = 24'h000000;
			1: begin
				zero_at = $urandom_range(0, 2);
				divs[zero_at*8 +: 8] = 8'd0;
			end
			default: ;
		endcase
		write_reg(bscrx_pkg::REG_CIPHER_MODE, $urandom_range(0, 1) ? DECRYPT : ENCRYPT);
		write_reg(bscrx_pkg::REG_SEED_BYTES, 64'(seed));
		write_reg(bscrx_pkg::REG_FALLBACK_DIV, 64'(divs));
		write_reg(bscrx_pkg::REG_KEY_A, ka);
		write_reg(bscrx_pkg::REG_KEY_A_LENGTH, 64'($urandom_range(0, 15)));
		write_reg(bscrx_pkg::REG_KEY_B, kb);
		write_reg(bscrx_pkg::REG_KEY_B_LENGTH, 64'($urandom_range(0, 15)));
	endtask

	// stimulus and verdict
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: zero keys and seeds keep every byte on the fallback path
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h5A, 1'b1);
		drain();

		// all divisors zero
		write_reg(bscrx_pkg::REG_FALLBACK_DIV, 64'h000000);
		send_word(8'h81, 1'b0);
		send_word(8'h7E, 1'b1);
		drain();

		// one zero divisor among nonzero ones
		write_reg(bscrx_pkg::REG_FALLBACK_DIV, 64'h030007);
		send_word(8'h01, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hFE, 1'b1);
		drain();

		// decrypt, full seeds, key lengths zero and above the key size
		write_reg(bscrx_pkg::REG_CIPHER_MODE, DECRYPT);
		write_reg(bscrx_pkg::REG_SEED_BYTES, 64'hFFFFFF);
		write_reg(bscrx_pkg::REG_FALLBACK_DIV, 64'hFFFFFF);
		write_reg(bscrx_pkg::REG_KEY_A, 64'h0123_4567_89AB_CDEF);
		write_reg(bscrx_pkg::REG_KEY_A_LENGTH, 64'd0);
		write_reg(bscrx_pkg::REG_KEY_B, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(bscrx_pkg::REG_KEY_B_LENGTH, 64'd15);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h0F, 1'b0);
		send_word(8'hF0, 1'b0);
		send_word(8'hA5, 1'b1);
		drain();

		// encrypt, lengths just above the key size and one
		write_reg(bscrx_pkg::REG_CIPHER_MODE, ENCRYPT);
		write_reg(bscrx_pkg::REG_SEED_BYTES, 64'h80017F);
		write_reg(bscrx_pkg::REG_KEY_A_LENGTH, 64'd9);
		write_reg(bscrx_pkg::REG_KEY_B_LENGTH, 64'd1);
		send_word(8'hFF, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'h3C, 1'b1);
		send_word(8'hC3, 1'b0);
		send_word(8'h55, 1'b1);
		drain();

		// decrypt with full-length keys
		write_reg(bscrx_pkg::REG_CIPHER_MODE, DECRYPT);
		write_reg(bscrx_pkg::REG_KEY_A_LENGTH, 64'd8);
		write_reg(bscrx_pkg::REG_KEY_B_LENGTH, 64'd8);
		send_word(8'h12, 1'b0);
		send_word(8'hED, 1'b0);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'h99, 1'b1);
		drain();

		// random phases, each under fresh settings
		for (int p = 0; p < PHASES; p++) begin
			random_setup();
			calm = (p % 4 == 2) || (p == 3);
			if (p == 3)
				hold_rx = 1'b1;
			if (p == 5) begin
				send_random_msgs(PHASE_WORDS / 2);
				drain();
				send_random_msgs(PHASE_WORDS - PHASE_WORDS / 2);
			end else begin
				send_random_msgs(PHASE_WORDS);
			end
			drain();
			calm = 1'b0;
		end

		if (fail_count == 0 && pending_words == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
